// File: rtl/kct_pkg.sv
// kct_pkg: shared constants and codes for the keyed count table
// table depth, index and data widths, opcode, status and sequencer state encodings
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

	// table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DATA_W      = 32;

	// command codes
	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_UPDATE = 2'd2,
		OP_LIST   = 2'd3
	} opcode_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EXISTS    = 3'd2,
		ST_FULL      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_CHK  = 6'b000100,
		S_UPD  = 6'b001000,
		S_INS  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

endpackage

`default_nettype wire

// File: rtl/keyed_count_table.sv
// keyed_count_table: insertion-ordered key/count table with linear key scan
// key and count stores are single-port synchronous memories
// depends on kct_pkg
// sequence: search, update and insert read and compare one entry per pass through
//   S_RD and S_CHK, then finish through S_UPD or S_INS where needed and then S_OUT;
//   list passes through S_RD, S_CHK and S_OUT and gives one result beat per entry.
// throughput: one command at a time; the next command is taken once the last result
//   of the current one sits in the output register.
// reset: arst_n clears the entry count and the control state; memory contents are
//   not cleared and are only read below the entry count.
`timescale 1ns / 1ps
`default_nettype none

module keyed_count_table (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          opcode,
	input  wire logic signed [kct_pkg::DATA_W-1:0]   key,
	input  wire logic signed [kct_pkg::DATA_W-1:0]   amount,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [2:0]                               status,
	output logic signed [kct_pkg::DATA_W-1:0]        out_key,
	output logic signed [kct_pkg::DATA_W-1:0]        out_count,
	output logic                                     last
);

	localparam int DW = kct_pkg::DATA_W;
	localparam int CW = kct_pkg::CNT_W;
	localparam int IW = kct_pkg::IDX_W;

	localparam logic [CW-1:0] DEPTH_C = CW'(kct_pkg::TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [DW-1:0] MAX_C   = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MIN_C   = {1'b1, {(DW-1){1'b0}}};

	// state storage
	logic [DW-1:0] key_mem   [kct_pkg::TABLE_DEPTH];
	logic [DW-1:0] count_mem [kct_pkg::TABLE_DEPTH];
	logic [DW-1:0] key_rd_q;
	logic [DW-1:0] count_rd_q;

	kct_pkg::state_t  state_q;
	kct_pkg::opcode_t op_q;
	logic [DW-1:0]    key_q;
	logic [DW-1:0]    amount_q;
	logic [CW-1:0]    entries_q;
	logic [CW-1:0]    idx_q;

	// pending result, waits for the output register
	kct_pkg::status_t pst_q;
	logic [DW-1:0]    pkey_q;
	logic [DW-1:0]    pcnt_q;
	logic             plast_q;

	// output register
	logic             out_valid_q;
	kct_pkg::status_t status_q;
	logic [DW-1:0]    out_key_q;
	logic [DW-1:0]    out_count_q;
	logic             last_q;

	logic             in_fire;
	logic             out_slot;
	logic             rd_en;
	logic             key_we;
	logic             count_we;
	logic [IW-1:0]    wr_addr;
	logic [DW-1:0]    count_wdata;
	logic [DW:0]      sum;
	logic [DW-1:0]    sat_sum;
	logic             key_hit;
	logic             scan_end;

	assign in_ready = (state_q == kct_pkg::S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_slot = !out_valid_q || out_ready;
	assign key_hit  = (key_rd_q == key_q);
	assign scan_end = ((idx_q + ONE_C) == entries_q);

	// saturating add of stored count and change
	always_comb begin
		sum = {count_rd_q[DW-1], count_rd_q} + {amount_q[DW-1], amount_q};
		if (sum[DW] != sum[DW-1]) begin
			sat_sum = sum[DW] ? MIN_C : MAX_C;
		end else begin
			sat_sum = sum[DW-1:0];
		end
	end

	// memory port controls
	always_comb begin
		rd_en       = (state_q == kct_pkg::S_RD);
		key_we      = (state_q == kct_pkg::S_INS);
		count_we    = (state_q == kct_pkg::S_INS) || (state_q == kct_pkg::S_UPD);
		wr_addr     = (state_q == kct_pkg::S_INS) ? entries_q[IW-1:0] : idx_q[IW-1:0];
		count_wdata = (state_q == kct_pkg::S_INS) ? amount_q : sat_sum;
	end

	// key store
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[wr_addr] <= key_q;
		end
		if (rd_en) begin
			key_rd_q <= key_mem[idx_q[IW-1:0]];
		end
	end

	// count store
	always_ff @(posedge clk) begin
		if (count_we) begin
			count_mem[wr_addr] <= count_wdata;
		end
		if (rd_en) begin
			count_rd_q <= count_mem[idx_q[IW-1:0]];
		end
	end

	// command payload capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q     <= kct_pkg::opcode_t'(opcode);
			key_q    <= key;
			amount_q <= amount;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= kct_pkg::S_IDLE;
			entries_q <= '0;
			idx_q     <= '0;
			pst_q     <= kct_pkg::ST_OK;
			pkey_q    <= '0;
			pcnt_q    <= '0;
			plast_q   <= 1'b0;
		end else begin
			unique case (state_q)
				kct_pkg::S_IDLE: begin
					if (in_fire) begin
						idx_q   <= '0;
						pkey_q  <= '0;
						pcnt_q  <= '0;
						plast_q <= 1'b1;
						if (kct_pkg::opcode_t'(opcode) == kct_pkg::OP_INSERT
						    && entries_q == DEPTH_C) begin
							pst_q   <= kct_pkg::ST_FULL;
							state_q <= kct_pkg::S_OUT;
						end else if (entries_q == '0) begin
							// nothing stored yet
							if (kct_pkg::opcode_t'(opcode) == kct_pkg::OP_INSERT) begin
								state_q <= kct_pkg::S_INS;
							end else begin
								pst_q   <= (kct_pkg::opcode_t'(opcode) == kct_pkg::OP_LIST)
								           ? kct_pkg::ST_EMPTY : kct_pkg::ST_NOT_FOUND;
								state_q <= kct_pkg::S_OUT;
							end
						end else begin
							state_q <= kct_pkg::S_RD;
						end
					end
				end
				kct_pkg::S_RD: begin
					state_q <= kct_pkg::S_CHK;
				end
				kct_pkg::S_CHK: begin
					if (op_q == kct_pkg::OP_LIST) begin
						pst_q   <= kct_pkg::ST_OK;
						pkey_q  <= key_rd_q;
						pcnt_q  <= count_rd_q;
						plast_q <= scan_end;
						state_q <= kct_pkg::S_OUT;
					end else if (key_hit) begin
						unique case (op_q)
							kct_pkg::OP_SEARCH: begin
								pst_q   <= kct_pkg::ST_OK;
								pkey_q  <= key_rd_q;
								pcnt_q  <= count_rd_q;
								state_q <= kct_pkg::S_OUT;
							end
							kct_pkg::OP_UPDATE: begin
								state_q <= kct_pkg::S_UPD;
							end
							default: begin
								pst_q   <= kct_pkg::ST_EXISTS;
								state_q <= kct_pkg::S_OUT;
							end
						endcase
					end else if (scan_end) begin
						// key absent from all occupied entries
						if (op_q == kct_pkg::OP_INSERT) begin
							state_q <= kct_pkg::S_INS;
						end else begin
							pst_q   <= kct_pkg::ST_NOT_FOUND;
							state_q <= kct_pkg::S_OUT;
						end
					end else begin
						idx_q   <= idx_q + ONE_C;
						state_q <= kct_pkg::S_RD;
					end
				end
				kct_pkg::S_UPD: begin
					pst_q   <= kct_pkg::ST_OK;
					pkey_q  <= key_rd_q;
					pcnt_q  <= sat_sum;
					state_q <= kct_pkg::S_OUT;
				end
				kct_pkg::S_INS: begin
					entries_q <= entries_q + ONE_C;
					pst_q     <= kct_pkg::ST_OK;
					pkey_q    <= key_q;
					pcnt_q    <= amount_q;
					state_q   <= kct_pkg::S_OUT;
				end
				kct_pkg::S_OUT: begin
					if (out_slot) begin
						if (plast_q) begin
							state_q <= kct_pkg::S_IDLE;
						end else begin
							// next entry of a list
							idx_q   <= idx_q + ONE_C;
							state_q <= kct_pkg::S_RD;
						end
					end
				end
				default: begin
					state_q <= kct_pkg::S_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == kct_pkg::S_OUT && out_slot) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == kct_pkg::S_OUT && out_slot) begin
			status_q    <= pst_q;
			out_key_q   <= pkey_q;
			out_count_q <= pcnt_q;
			last_q      <= plast_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_count = out_count_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// testbench for keyed_count_table: directed and random commands with a shadow table
// that predicts every result beat, random idling on both sides and a long output hold
// depends on kct_pkg and rtl/keyed_count_table.sv
`timescale 1ns / 1ps

module testbench;

	localparam logic signed [31:0] S32_MAX     = 32'sh7fff_ffff;
	localparam logic signed [31:0] S32_MIN     = 32'sh8000_0000;
	localparam int                 CYCLE_LIMIT = 1_000_000;
	localparam int                 HOLD_CYCLES = 400;
	localparam int                 DRAIN_WAIT  = 2 * kct_pkg::TABLE_DEPTH + 8;

	typedef struct {
		logic [2:0]         status;
		logic signed [31:0] key;
		logic signed [31:0] count;
		logic               last;
	} table_result_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	logic [1:0]         opcode    = 2'd0;
	logic signed [31:0] key       = '0;
	logic signed [31:0] amount    = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic signed [31:0] out_key;
	logic signed [31:0] out_count;
	logic               last;

	// shadow copy of the table
	logic signed [31:0] shadow_keys[kct_pkg::TABLE_DEPTH];
	logic signed [31:0] shadow_counts[kct_pkg::TABLE_DEPTH];
	int                 shadow_fill = 0;

	table_result_t pending_results[$];
	int            mismatch_count = 0;
	int            tx_idle_pct    = 0;
	int            rx_idle_pct    = 0;
	int            hold_left      = 0;
	int            cycle_count    = 0;

	keyed_count_table uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.key       (key),
		.amount    (amount),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.out_key   (out_key),
		.out_count (out_count),
		.last      (last)
	);

	always #1 clk = ~clk;

	// linear search of the shadow table, -1 when absent
	function automatic int find_key(logic signed [31:0] k);
		for (int i = 0; i < shadow_fill; i++)
			if (shadow_keys[i] == k)
				return i;
		return -1;
	endfunction

	// signed add clamped to the 32-bit range
	function automatic logic signed [31:0] sat_add(logic signed [31:0] base,
			logic signed [31:0] delta);
		logic [32:0] sum;
		sum = {base[31], base} + {delta[31], delta};
		if (sum[32] != sum[31])
			return sum[32] ? S32_MIN : S32_MAX;
		return sum[31:0];
	endfunction

	task automatic queue_result(logic [2:0] st, logic signed [31:0] k,
			logic signed [31:0] c, logic lst);
		pending_results.push_back('{st, k, c, lst});
	endtask

	// apply one accepted command to the shadow table and queue its result beats
	task automatic apply_table_cmd(kct_pkg::opcode_t op, logic signed [31:0] k,
			logic signed [31:0] a);
		int idx;
		idx = find_key(k);
		case (op)
			kct_pkg::OP_INSERT: begin
				if (shadow_fill >= kct_pkg::TABLE_DEPTH) begin
					queue_result(kct_pkg::ST_FULL, '0, '0, 1'b1);
				end else if (idx >= 0) begin
					queue_result(kct_pkg::ST_EXISTS, '0, '0, 1'b1);
				end else begin
					shadow_keys[shadow_fill]   = k;
					shadow_counts[shadow_fill] = a;
					shadow_fill++;
					queue_result(kct_pkg::ST_OK, k, a, 1'b1);
				end
			end
			kct_pkg::OP_SEARCH: begin
				if (idx < 0)
					queue_result(kct_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
				else
					queue_result(kct_pkg::ST_OK, shadow_keys[idx], shadow_counts[idx],
						1'b1);
			end
			kct_pkg::OP_UPDATE: begin
				if (idx < 0) begin
					queue_result(kct_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					shadow_counts[idx] = sat_add(shadow_counts[idx], a);
					queue_result(kct_pkg::ST_OK, shadow_keys[idx], shadow_counts[idx],
						1'b1);
				end
			end
			default: begin
				if (shadow_fill == 0)
					queue_result(kct_pkg::ST_EMPTY, '0, '0, 1'b1);
				else
					for (int i = 0; i < shadow_fill; i++)
						queue_result(kct_pkg::ST_OK, shadow_keys[i], shadow_counts[i],
							i == shadow_fill - 1);
			end
		endcase
	endtask

	// send one command beat, with random idle cycles ahead of it
	task automatic issue_cmd(kct_pkg::opcode_t op, logic signed [31:0] k,
			logic signed [31:0] a);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		key      <= k;
		amount   <= a;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		apply_table_cmd(op, k, a);
	endtask

	// mostly known keys, some one-bit neighbors, some fresh values
	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (shadow_fill > 0 && r < 55)
			return shadow_keys[$urandom_range(shadow_fill - 1)];
		if (shadow_fill > 0 && r < 70)
			return shadow_keys[$urandom_range(shadow_fill - 1)]
				^ (32'd1 << $urandom_range(31));
		return $urandom();
	endfunction

	function automatic logic signed [31:0] pick_amount();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return S32_MAX;
		if (r < 20)
			return S32_MIN;
		if (r < 50)
			return $urandom_range(200) - 100;
		return $urandom();
	endfunction

	task automatic issue_random_cmd();
		kct_pkg::opcode_t op;
		int               r;
		r = $urandom_range(99);
		if (r < 35)
			op = kct_pkg::OP_INSERT;
		else if (r < 60)
			op = kct_pkg::OP_SEARCH;
		else if (r < 92)
			op = kct_pkg::OP_UPDATE;
		else
			op = kct_pkg::OP_LIST;
		issue_cmd(op, pick_key(), pick_amount());
	endtask

	task automatic test_empty_table();
		issue_cmd(kct_pkg::OP_LIST, '0, '0);
		issue_cmd(kct_pkg::OP_SEARCH, 32'sd5, '0);
		issue_cmd(kct_pkg::OP_UPDATE, -32'sd5, 32'sd1);
	endtask

	task automatic test_insert_search();
		issue_cmd(kct_pkg::OP_INSERT, S32_MAX, S32_MAX);
		issue_cmd(kct_pkg::OP_INSERT, S32_MIN, S32_MIN);
		issue_cmd(kct_pkg::OP_INSERT, '0, '0);
		issue_cmd(kct_pkg::OP_INSERT, -32'sd1, 32'sd100);
		// duplicate key is refused
		issue_cmd(kct_pkg::OP_INSERT, S32_MAX, 32'sd7);
		issue_cmd(kct_pkg::OP_SEARCH, S32_MIN, '0);
		issue_cmd(kct_pkg::OP_SEARCH, 32'sd1, '0);
		issue_cmd(kct_pkg::OP_SEARCH, S32_MAX - 1, '0);
	endtask

	task automatic test_saturating_update();
		issue_cmd(kct_pkg::OP_UPDATE, S32_MAX, 32'sd1);
		issue_cmd(kct_pkg::OP_UPDATE, S32_MIN, -32'sd1);
		issue_cmd(kct_pkg::OP_UPDATE, '0, S32_MAX);
		issue_cmd(kct_pkg::OP_UPDATE, '0, S32_MAX);
		issue_cmd(kct_pkg::OP_UPDATE, -32'sd1, S32_MIN);
		issue_cmd(kct_pkg::OP_UPDATE, -32'sd1, -32'sd100);
		issue_cmd(kct_pkg::OP_UPDATE, S32_MAX, S32_MIN);
		issue_cmd(kct_pkg::OP_LIST, '0, '0);
	endtask

	task automatic test_random_traffic(int n, int tx_pct, int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n)
			issue_random_cmd();
	endtask

	// receiver holds off while commands keep coming, so the input stalls
	task automatic test_receiver_hold();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_left   = HOLD_CYCLES;
		repeat (12)
			issue_random_cmd();
	endtask

	task automatic test_full_table();
		logic signed [31:0] k;
		while (shadow_fill < kct_pkg::TABLE_DEPTH) begin
			do
				k = $urandom();
			while (find_key(k) >= 0);
			issue_cmd(kct_pkg::OP_INSERT, k, pick_amount());
		end
		do
			k = $urandom();
		while (find_key(k) >= 0);
		issue_cmd(kct_pkg::OP_INSERT, k, 32'sd1);
		// fullness wins over the duplicate check
		issue_cmd(kct_pkg::OP_INSERT, shadow_keys[0], 32'sd1);
		issue_cmd(kct_pkg::OP_LIST, '0, '0);
		issue_cmd(kct_pkg::OP_SEARCH, shadow_keys[kct_pkg::TABLE_DEPTH - 1], '0);
		issue_cmd(kct_pkg::OP_UPDATE, shadow_keys[kct_pkg::TABLE_DEPTH - 1], -32'sd100);
		issue_cmd(kct_pkg::OP_SEARCH, k, '0);
	endtask

	// output side: random ready, or a counted hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	task automatic note_mismatch(string what, table_result_t want, table_result_t got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s: expected status %0d key %0d count %0d last %0b",
				$realtime, what, want.status, want.key, want.count, want.last);
			$display("    got status %0d key %0d count %0d last %0b",
				got.status, got.key, got.count, got.last);
		end
	endtask

	// compare each accepted result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		table_result_t got;
		table_result_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got = '{status, out_key, out_count, last};
			if (pending_results.size() == 0) begin
				want = '{'0, '0, '0, 1'b0};
				note_mismatch("unexpected beat", want, got);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.key !== want.key ||
						got.count !== want.count || got.last !== want.last)
					note_mismatch("result mismatch", want, got);
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** keyed_count_table: FAILED **");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 21;
		rx_idle_pct = 78;
		test_empty_table();
		test_insert_search();
		test_saturating_update();
		test_random_traffic(48, 21, 78);
		test_random_traffic(48, 78, 21);
		test_random_traffic(48, 0, 0);
		test_receiver_hold();
		test_full_table();
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("** keyed_count_table: PASSED **");
		else
			$display("** keyed_count_table: FAILED **");
		$finish;
	end

endmodule
